[src/dsi_pkg.sv]
// ----------------------------------------------------------------------------
// dsi_pkg
// Types and character codes shared by the decimal string to integer core.
// ----------------------------------------------------------------------------
package dsi_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned CHAR_W  = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // one input item: a byte of the string
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } dsi_in_t;

    // one result item per string
    typedef struct packed {
        logic signed [VALUE_W-1:0] parsed_value;
        logic                      bad_char;
    } dsi_out_t;

    // running parse state
    typedef struct packed {
        logic [VALUE_W-1:0] accum;
        logic               negate;
        logic               frozen;
        logic               error;
    } dsi_state_t;

endpackage

[src/dsi_step.sv]
// ----------------------------------------------------------------------------
// dsi_step
// Next parse state for one byte: classify, then acc*10 +/- digit.
// ----------------------------------------------------------------------------
module dsi_step (
    input  dsi_pkg::dsi_state_t       cur,
    input  logic [dsi_pkg::CHAR_W-1:0] char_code,
    output dsi_pkg::dsi_state_t       nxt
);
    import dsi_pkg::*;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_MINUS,
        CLS_SEP,
        CLS_NUL,
        CLS_BAD
    } char_class_t;

    char_class_t        cls;
    logic [VALUE_W-1:0] times_ten;
    logic [VALUE_W-1:0] digit;
    logic [CHAR_W-1:0]  digit_raw;

    // classify the byte
    always_comb
    begin
        priority if (char_code >= CH_ZERO && char_code <= CH_NINE)
            cls = CLS_DIGIT;
        else if (char_code == CH_MINUS)
            cls = CLS_MINUS;
        else if (char_code == CH_DOT || char_code == CH_COMMA)
            cls = CLS_SEP;
        else if (char_code == CH_NUL)
            cls = CLS_NUL;
        else
            cls = CLS_BAD;
    end

    // scale by ten as two shifts and an add
    assign times_ten = {cur.accum[VALUE_W-4:0], 3'b000} + {cur.accum[VALUE_W-2:0], 1'b0};
    assign digit_raw = char_code - CH_ZERO;
    assign digit     = {{(VALUE_W-4){1'b0}}, digit_raw[3:0]};

    // state update
    always_comb
    begin
        nxt = cur;
        unique case (cls)
            CLS_DIGIT:
            begin
                if (!cur.frozen)
                    nxt.accum = cur.negate ? (times_ten - digit) : (times_ten + digit);
            end
            CLS_MINUS:
            begin
                if (!cur.frozen)
                begin
                    nxt.accum  = times_ten;
                    nxt.negate = ~cur.negate;
                end
            end
            CLS_SEP:
                nxt.frozen = 1'b1;
            CLS_NUL:
                nxt = cur;
            CLS_BAD:
                nxt.error = 1'b1;
            default:
                nxt = cur;
        endcase
    end

endmodule

[src/decimal_string_to_integer_core.sv]
// ----------------------------------------------------------------------------
// decimal_string_to_integer_core
// Streams ASCII decimal bytes and gives one signed 64-bit value per string.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  char      in         char_valid / char_ready    char_item   (dsi_in_t)
//  result    out        result_valid / result_ready result_item (dsi_out_t)
//
//  one byte per cycle unless stalled; a result is offered once its last byte
//  has moved from the input register (the result register loads from it)
//  the single 64-bit multiply-by-ten and add sets the cycle time
//  reset clears the parse state and both valid flags
//  a stalled result only holds back a waiting last byte; other bytes flow on
// ----------------------------------------------------------------------------
module decimal_string_to_integer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  dsi_pkg::dsi_in_t  char_item,
    output logic              result_valid,
    input  logic              result_ready,
    output dsi_pkg::dsi_out_t result_item
);
    import dsi_pkg::*;

    logic       in_vld_reg;
    dsi_in_t    in_item_reg;
    dsi_state_t state_reg;
    dsi_state_t state_next;
    logic       res_vld_reg;
    logic       res_vld_next;
    dsi_out_t   res_item_reg;
    dsi_out_t   res_item_next;
    logic       stall;
    logic       advance;
    logic       finish;

    // byte update logic
    dsi_step u_step (
        .cur       (state_reg),
        .char_code (in_item_reg.char_code),
        .nxt       (state_next)
    );

    // flow control
    assign stall      = in_vld_reg && in_item_reg.last_char && res_vld_reg && !result_ready;
    assign char_ready = !stall;
    assign advance    = in_vld_reg && !stall;
    assign finish     = advance && in_item_reg.last_char;

    // result formation
    always_comb
    begin
        res_item_next.bad_char     = state_next.error;
        res_item_next.parsed_value = state_next.error ? '0 : state_next.accum;
        if (finish)
            res_vld_next = 1'b1;
        else if (result_ready)
            res_vld_next = 1'b0;
        else
            res_vld_next = res_vld_reg;
    end

    // control registers and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            if (char_ready)
                in_vld_reg <= char_valid;
            res_vld_reg <= res_vld_next;
            if (finish)
                state_reg <= '0;
            else if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            in_item_reg <= char_item;
        if (finish)
            res_item_reg <= res_item_next;
    end

    assign result_valid = res_vld_reg;
    assign result_item  = res_item_reg;

    // input only waits behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> (in_vld_reg && in_item_reg.last_char && res_vld_reg))
        else $error("input held without a pending last item");

    // an error result carries a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.bad_char) |-> (result_item.parsed_value == '0))
        else $error("error result with nonzero value");

    // state is cleared after each string
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (state_reg == '0))
        else $error("parse state not cleared after last item");

    // a finished string always yields a valid result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> res_vld_reg)
        else $error("result lost");

endmodule
